// File: src/ggbs_pkg.sv
package ggbs_pkg;

   localparam int REQ_W = 240;
   localparam int RSP_W = 40;
   localparam int CX_W = 40;
   localparam int ANG_W = 34;
   localparam int NUM_W = 48;
   localparam int DEN_W = 33;
   localparam int MUL_W = 33;

   localparam logic signed [ANG_W-1:0] HALF_PI_Q28 = 34'sd421657428;
   localparam logic signed [31:0] GAP_MIN_Q16 = 32'sd3276;
   localparam logic signed [31:0] GAP_SUB_Q16 = 32'sd32768;

   localparam logic [15:0] LGAIN_RST = 16'd2048;
   localparam logic [15:0] LLIM_RST = 16'd1638;
   localparam logic [15:0] AGAIN_RST = 16'd6144;
   localparam logic [15:0] ALIM_RST = 16'd4915;
   localparam logic [15:0] GWEIGHT_RST = 16'd7168;
   localparam logic [15:0] ALPHA_RST = 16'd4096;
   localparam logic [15:0] LDB_RST = 16'd410;
   localparam logic [15:0] ADB_RST = 16'd41;

   typedef enum logic [1:0] {
      OP_ODOM = 2'd0,
      OP_GAP  = 2'd1,
      OP_GOAL = 2'd2,
      OP_NONE = 2'd3
   } opcode_type;

   typedef enum logic [2:0] {
      REG_LGAIN   = 3'd0,
      REG_LLIM    = 3'd1,
      REG_AGAIN   = 3'd2,
      REG_ALIM    = 3'd3,
      REG_GWEIGHT = 3'd4,
      REG_ALPHA   = 3'd5,
      REG_LDB     = 3'd6,
      REG_ADB     = 3'd7
   } reg_index_type;

   typedef enum logic [4:0] {
      S_IDLE, S_QA, S_QB, S_QC, S_QD, S_QE, S_YAW, S_ERR, S_SQ1, S_SQ2, S_SQ3,
      S_ROOT, S_BL1, S_BL2, S_BL3, S_DIV, S_ANG, S_LIN, S_FIN, S_OUT
   } state_type;

   // atan(2^-i) in Q5.28
   function automatic logic signed [ANG_W-1:0] atan_step(input logic [4:0] i);
      logic signed [ANG_W-1:0] r;
      case (i)
         5'd0: r = 34'sd210828714;
         5'd1: r = 34'sd124459457;
         5'd2: r = 34'sd65760959;
         5'd3: r = 34'sd33381290;
         5'd4: r = 34'sd16755422;
         5'd5: r = 34'sd8385879;
         5'd6: r = 34'sd4193963;
         5'd7: r = 34'sd2097109;
         5'd8: r = 34'sd1048571;
         5'd9: r = 34'sd524287;
         5'd10: r = 34'sd262144;
         5'd29, 5'd30, 5'd31: r = '0;
         default: r = 34'sd1 <<< (5'd28 - i);
      endcase
      return r;
   endfunction

endpackage

// File: src/ggbs_cordic.sv
module ggbs_cordic
   import ggbs_pkg::*;
#(
   parameter int STEPS = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic signed [CX_W-1:0]  x_in,
   input  logic signed [CX_W-1:0]  y_in,
   output logic                    busy,
   output logic signed [15:0]      angle
);

   localparam int IW = $clog2(STEPS);

   logic signed [CX_W-1:0]  x_ff, y_ff, xs, ys, dx, dy;
   logic signed [ANG_W-1:0] z_ff, zs, step, zr;
   logic [IW-1:0]           cnt_ff;
   logic                    busy_ff, zero_ff;

   always_comb begin
      xs = x_in;
      ys = y_in;
      zs = '0;
      if (x_in < 0) begin
         if (y_in >= 0) begin
            xs = y_in;
            ys = -x_in;
            zs = HALF_PI_Q28;
         end else begin
            xs = -y_in;
            ys = x_in;
            zs = -HALF_PI_Q28;
         end
      end
      dx = y_ff >>> cnt_ff;
      dy = x_ff >>> cnt_ff;
      step = atan_step(5'(cnt_ff));
      zr = (z_ff + (34'sd1 <<< 15)) >>> 16;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else if (start) begin
         busy_ff <= 1'b1;
      end else if (busy_ff && cnt_ff == IW'(STEPS - 1)) begin
         busy_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         x_ff <= xs;
         y_ff <= ys;
         z_ff <= zs;
         cnt_ff <= '0;
         zero_ff <= (x_in == 0) && (y_in == 0);
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff + 1'b1;
         if (y_ff >= 0) begin
            x_ff <= x_ff + dx;
            y_ff <= y_ff - dy;
            z_ff <= z_ff + step;
         end else begin
            x_ff <= x_ff - dx;
            y_ff <= y_ff + dy;
            z_ff <= z_ff - step;
         end
      end
   end

   assign busy = busy_ff;
   assign angle = zero_ff ? 16'sd0 : 16'(zr);

endmodule

// File: src/ggbs_isqrt.sv
module ggbs_isqrt
   import ggbs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] v_in,
   output logic        busy,
   output logic [31:0] root
);

   logic [63:0] rem_ff, root_ff, bit_ff, trial;

   assign trial = root_ff + bit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         bit_ff <= '0;
      end else if (start) begin
         bit_ff <= 64'd1 << 62;
      end else begin
         bit_ff <= bit_ff >> 2;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= v_in;
         root_ff <= '0;
      end else if (bit_ff != 0) begin
         if (rem_ff >= trial) begin
            rem_ff <= rem_ff - trial;
            root_ff <= (root_ff >> 1) + bit_ff;
         end else begin
            root_ff <= root_ff >> 1;
         end
      end
   end

   assign busy = (bit_ff != 0);
   assign root = root_ff[31:0];

endmodule

// File: src/ggbs_div.sv
module ggbs_div
   import ggbs_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic signed [NUM_W-1:0] num_in,
   input  logic [DEN_W-1:0]        den_in,
   output logic                    busy,
   output logic signed [NUM_W-1:0] quot
);

   localparam int CW = $clog2(NUM_W);

   logic [DEN_W-1:0] rem_ff, den_ff;
   logic [NUM_W-1:0] n_ff;
   logic [DEN_W:0]   trial;
   logic [CW-1:0]    cnt_ff;
   logic             busy_ff, neg_ff, ge;

   assign trial = {rem_ff, n_ff[NUM_W-1]};
   assign ge = trial >= {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else if (start) begin
         busy_ff <= 1'b1;
      end else if (busy_ff && cnt_ff == CW'(NUM_W - 1)) begin
         busy_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         den_ff <= den_in;
         neg_ff <= num_in < 0;
         n_ff <= (num_in < 0) ? NUM_W'(-num_in) : NUM_W'(num_in);
         cnt_ff <= '0;
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff + 1'b1;
         rem_ff <= ge ? DEN_W'(trial - {1'b0, den_ff}) : DEN_W'(trial);
         n_ff <= {n_ff[NUM_W-2:0], ge};
      end
   end

   assign busy = busy_ff;
   assign quot = neg_ff ? -$signed(n_ff) : $signed(n_ff);

endmodule

// File: src/gap_goal_blend_steering.sv
// gap and goal blending steering controller
// req channel: tuser carries the opcode (odometry, gap update, goal update).
// gap and goal updates update the held state and produce no
// response; opcode three is dropped.
// each odometry request produces one rsp with the linear speed and turn rate.
// the first odometry request after reset latches the origin pose.
// an odometry request runs through a 48-step blend divider and a 32-step
// square root, with two passes through the CORDIC unit of CORDIC_STEPS
// steps each and a single shared 33x33 multiplier used for every product.
// req_tready is low while an odometry request is being worked on, so the
// block takes no new request until the last one is through.
// the result sits in an output register; if the receiver stalls the block
// still accepts the next request and holds its new result until the
// register frees up.
// csr writes take effect at once and must only occur while idle.
// reset is synchronous: config returns to defaults, the origin is cleared,
// held gap and goal are zeroed and any pending rsp is dropped.
module gap_goal_blend_steering
   import ggbs_pkg::*;
#(
   parameter int CORDIC_STEPS = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   // pos_x, pos_y, quat_x, quat_y, quat_z, quat_w, gap_angle, gap_distance,
   // target_x, target_y
   input  logic [REQ_W-1:0] req_tdata,
   // opcode
   input  logic [1:0]       req_tuser,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   // linear_speed, angular_rate, zero fill
   output logic [RSP_W-1:0] rsp_tdata,
   input  logic             csr_we,
   input  logic [2:0]       csr_index,
   input  logic [15:0]      csr_wdata
);

   state_type state_ff, state_in;
   opcode_type opcode;
   logic req_accept, odom_accept;

   logic [15:0] lgain_ff, llim_ff, again_ff, alim_ff, gweight_ff, alpha_ff, ldb_ff, adb_ff;

   logic olatch_ff;
   logic signed [31:0] ox_ff, oy_ff, gx_ff, gy_ff, gdist_ff;
   logic signed [15:0] ohead_ff, gang_ff;

   logic signed [31:0] px_ff, py_ff;
   logic signed [15:0] qx_ff, qy_ff, qz_ff, qw_ff;

   logic signed [MUL_W-1:0]   mul_a, mul_b;
   logic signed [2*MUL_W-1:0] prod_ff, sum66, rnd;
   logic signed [63:0]        acc_ff;
   logic signed [CX_W-1:0]    ynum_ff, cord_x, cord_y;
   logic signed [16:0]        heading_ff;
   logic signed [33:0]        ex_ff, ey_ff, ex_n, ey_n;
   logic [33:0]               ax, ay, am;
   logic [30:0]               axs_ff, ays_ff;
   logic [1:0]                sh_ff, sh;
   logic [31:0]               root_ff;
   logic signed [15:0]        aim_dir_ff, yaw;
   logic signed [17:0]        gap_dir;
   logic signed [31:0]        deff;
   logic signed [48:0]        enddir_ff, diff;
   logic signed [47:0]        rate_ff, rate_lim, rate_c;
   logic [53:0]               lin_p, spd;
   logic [15:0]               spd_c, lspd_ff;
   logic signed [16:0]        arate_ff;
   logic                      rsp_valid_ff;
   logic [RSP_W-1:0]          rsp_data_ff;

   logic cord_start, cord_busy, isq_start, isq_busy, div_start, div_busy, out_load;
   logic signed [15:0] cord_angle;
   logic [31:0] isq_root;
   logic signed [NUM_W-1:0] div_quot;

   assign opcode = opcode_type'(req_tuser);
   assign req_accept = req_tvalid && req_tready;
   assign odom_accept = req_accept && (opcode == OP_ODOM);

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         lgain_ff <= LGAIN_RST;
         llim_ff <= LLIM_RST;
         again_ff <= AGAIN_RST;
         alim_ff <= ALIM_RST;
         gweight_ff <= GWEIGHT_RST;
         alpha_ff <= ALPHA_RST;
         ldb_ff <= LDB_RST;
         adb_ff <= ADB_RST;
      end else if (csr_we) begin
         unique case (reg_index_type'(csr_index))
            REG_LGAIN:   lgain_ff <= csr_wdata;
            REG_LLIM:    llim_ff <= csr_wdata;
            REG_AGAIN:   again_ff <= csr_wdata;
            REG_ALIM:    alim_ff <= csr_wdata;
            REG_GWEIGHT: gweight_ff <= csr_wdata;
            REG_ALPHA:   alpha_ff <= csr_wdata;
            REG_LDB:     ldb_ff <= csr_wdata;
            REG_ADB:     adb_ff <= csr_wdata;
         endcase
      end
   end

   // held state
   always_ff @(posedge clock) begin
      if (reset) begin
         olatch_ff <= 1'b0;
         ox_ff <= '0;
         oy_ff <= '0;
         ohead_ff <= '0;
         gx_ff <= '0;
         gy_ff <= '0;
         gang_ff <= '0;
         gdist_ff <= '0;
      end else begin
         if (req_accept && opcode == OP_GAP) begin
            gang_ff <= req_tdata[143:128];
            gdist_ff <= req_tdata[175:144];
         end
         if (req_accept && opcode == OP_GOAL) begin
            gx_ff <= req_tdata[207:176];
            gy_ff <= req_tdata[239:208];
         end
         if (state_ff == S_YAW && !cord_busy && !olatch_ff) begin
            olatch_ff <= 1'b1;
            ox_ff <= px_ff;
            oy_ff <= py_ff;
            ohead_ff <= yaw;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: if (odom_accept) state_in = S_QA;
         S_QA:   state_in = S_QB;
         S_QB:   state_in = S_QC;
         S_QC:   state_in = S_QD;
         S_QD:   state_in = S_QE;
         S_QE:   state_in = S_YAW;
         S_YAW:  if (!cord_busy) state_in = S_ERR;
         S_ERR:  state_in = S_SQ1;
         S_SQ1:  state_in = S_SQ2;
         S_SQ2:  state_in = S_SQ3;
         S_SQ3:  state_in = S_ROOT;
         S_ROOT: if (!isq_busy && !cord_busy) state_in = S_BL1;
         S_BL1:  state_in = S_BL2;
         S_BL2:  state_in = S_BL3;
         S_BL3:  state_in = S_DIV;
         S_DIV:  if (!div_busy) state_in = S_ANG;
         S_ANG:  state_in = S_LIN;
         S_LIN:  state_in = S_FIN;
         S_FIN:  state_in = S_OUT;
         S_OUT:  if (!rsp_valid_ff || rsp_tready) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // datapath helpers
   always_comb begin
      sum66 = prod_ff + (2*MUL_W)'(acc_ff);
      yaw = cord_angle;
      if (olatch_ff) begin
         ex_n = 34'(gx_ff) - (34'(px_ff) - 34'(ox_ff));
         ey_n = 34'(gy_ff) - (34'(py_ff) - 34'(oy_ff));
      end else begin
         ex_n = 34'(gx_ff);
         ey_n = 34'(gy_ff);
      end
      ax = (ex_ff < 0) ? 34'(-ex_ff) : 34'(ex_ff);
      ay = (ey_ff < 0) ? 34'(-ey_ff) : 34'(ey_ff);
      am = ax | ay;
      sh = am[33] ? 2'd3 : am[32] ? 2'd2 : am[31] ? 2'd1 : 2'd0;
      gap_dir = 18'(gang_ff) + 18'(heading_ff);
      deff = (gdist_ff <= GAP_MIN_Q16) ? GAP_SUB_Q16 : gdist_ff;
      diff = enddir_ff - 49'(heading_ff);
      rnd = prod_ff + 66'sd2048;
      lin_p = {3'b0, prod_ff[50:0]} << sh_ff;
      spd = (lin_p + 54'd32768) >> 16;
      spd_c = (spd > {38'b0, llim_ff}) ? llim_ff : spd[15:0];
      if (spd_c < ldb_ff) spd_c = '0;
      rate_lim = 48'($signed({1'b0, alim_ff}));
      if (rate_ff > rate_lim) rate_c = rate_lim;
      else if (rate_ff < -rate_lim) rate_c = -rate_lim;
      else rate_c = rate_ff;
      if (rate_c < 48'($signed({1'b0, adb_ff})) && rate_c > -48'($signed({1'b0, adb_ff})))
         rate_c = '0;
   end

   // sequencer outputs
   always_comb begin
      req_tready = (state_ff == S_IDLE);
      cord_start = 1'b0;
      cord_x = '0;
      cord_y = '0;
      isq_start = 1'b0;
      div_start = 1'b0;
      out_load = 1'b0;
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         S_QA: begin
            mul_a = 33'(qw_ff);
            mul_b = 33'(qz_ff);
         end
         S_QB: begin
            mul_a = 33'(qx_ff);
            mul_b = 33'(qy_ff);
         end
         S_QC: begin
            mul_a = 33'(qy_ff);
            mul_b = 33'(qy_ff);
         end
         S_QD: begin
            mul_a = 33'(qz_ff);
            mul_b = 33'(qz_ff);
         end
         S_QE: begin
            cord_start = 1'b1;
            cord_x = CX_W'((66'sd1 <<< 28) - (sum66 <<< 1));
            cord_y = ynum_ff;
         end
         S_ERR: begin
            cord_start = 1'b1;
            cord_x = CX_W'(ex_ff);
            cord_y = CX_W'(ey_ff);
         end
         S_SQ1: begin
            mul_a = {2'b0, axs_ff};
            mul_b = {2'b0, axs_ff};
         end
         S_SQ2: begin
            mul_a = {2'b0, ays_ff};
            mul_b = {2'b0, ays_ff};
         end
         S_SQ3: isq_start = 1'b1;
         S_BL1: begin
            mul_a = $signed({13'b0, gweight_ff, 4'b0});
            mul_b = 33'(gap_dir);
         end
         S_BL2: begin
            mul_a = 33'(deff);
            mul_b = 33'(aim_dir_ff);
         end
         S_BL3: div_start = 1'b1;
         S_ANG: begin
            mul_a = $signed({17'b0, again_ff});
            mul_b = 33'(diff);
         end
         S_LIN: begin
            mul_a = $signed({17'b0, lgain_ff});
            mul_b = $signed({1'b0, root_ff});
         end
         S_OUT: out_load = !rsp_valid_ff || rsp_tready;
         default: ;
      endcase
   end

   // shared multiplier and working registers
   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
      if (odom_accept) begin
         px_ff <= req_tdata[31:0];
         py_ff <= req_tdata[63:32];
         qx_ff <= req_tdata[79:64];
         qy_ff <= req_tdata[95:80];
         qz_ff <= req_tdata[111:96];
         qw_ff <= req_tdata[127:112];
      end
      case (state_ff)
         S_QB, S_QD, S_SQ2, S_BL2: acc_ff <= 64'(prod_ff);
         S_QC: ynum_ff <= CX_W'(sum66 <<< 1);
         S_YAW: begin
            heading_ff <= olatch_ff ? 17'(yaw) - 17'(ohead_ff) : 17'sd0;
            ex_ff <= ex_n;
            ey_ff <= ey_n;
         end
         S_ERR: begin
            sh_ff <= sh;
            axs_ff <= 31'(ax >> sh);
            ays_ff <= 31'(ay >> sh);
         end
         S_ROOT: begin
            root_ff <= isq_root;
            aim_dir_ff <= cord_angle;
         end
         S_DIV: enddir_ff <= 49'(div_quot);
         S_LIN: rate_ff <= 48'(rnd >>> 12);
         S_FIN: begin
            lspd_ff <= spd_c;
            arate_ff <= 17'(rate_c);
         end
         default: ;
      endcase
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_data_ff <= {7'b0, arate_ff, lspd_ff};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;

   ggbs_cordic #(
      .STEPS(CORDIC_STEPS)
   ) u_cordic (
      .clock(clock),
      .reset(reset),
      .start(cord_start),
      .x_in(cord_x),
      .y_in(cord_y),
      .busy(cord_busy),
      .angle(cord_angle)
   );

   ggbs_isqrt u_isqrt (
      .clock(clock),
      .reset(reset),
      .start(isq_start),
      .v_in(64'(sum66)),
      .busy(isq_busy),
      .root(isq_root)
   );

   ggbs_div u_div (
      .clock(clock),
      .reset(reset),
      .start(div_start),
      .num_in(NUM_W'(sum66)),
      .den_in({13'b0, alpha_ff, 4'b0} + {1'b0, deff}),
      .busy(div_busy),
      .quot(div_quot)
   );

endmodule

// File: src/ggbs_checker.sv
module ggbs_checker
   import ggbs_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       req_tvalid,
   input logic       req_tready,
   input logic [1:0] req_tuser,
   input logic       rsp_tvalid,
   input logic       rsp_tready
);

   // stalled rsp stays up
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("rsp dropped while stalled");

   a_odom_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser == OP_ODOM |=> !req_tready)
      else $error("ready after odometry request");

   a_update_free: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser != OP_ODOM |=> req_tready)
      else $error("update request blocked the block");

   a_rsp_from_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> !$past(req_tready))
      else $error("rsp appeared while idle");

endmodule

bind gap_goal_blend_steering ggbs_checker u_ggbs_checker (.*);

// File: bench/gap_goal_blend_steering_tb.sv
`timescale 1ns / 100ps

module gap_goal_blend_steering_tb
   import ggbs_pkg::*;
();

   localparam int STEPS = 16;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int ITEMS_PER_PHASE = 325;

   typedef struct {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [15:0] quat_x;
      logic signed [15:0] quat_y;
      logic signed [15:0] quat_z;
      logic signed [15:0] quat_w;
      logic signed [15:0] gap_angle;
      logic signed [31:0] gap_distance;
      logic signed [31:0] target_x;
      logic signed [31:0] target_y;
   } request_type;

   typedef struct {
      logic [15:0]        speed;
      logic signed [16:0] rate;
   } command_type;

   class scoreboard_type;
      logic [15:0] regs[8];
      bit          has_origin;
      longint      org_x, org_y, org_head;
      longint      goal_x, goal_y, gap_ang, gap_dist;
      command_type pending[$];

      function new();
         regs[REG_LGAIN] = LGAIN_RST;
         regs[REG_LLIM] = LLIM_RST;
         regs[REG_AGAIN] = AGAIN_RST;
         regs[REG_ALIM] = ALIM_RST;
         regs[REG_GWEIGHT] = GWEIGHT_RST;
         regs[REG_ALPHA] = ALPHA_RST;
         regs[REG_LDB] = LDB_RST;
         regs[REG_ADB] = ADB_RST;
         has_origin = 0;
         org_x = 0; org_y = 0; org_head = 0;
         goal_x = 0; goal_y = 0; gap_ang = 0; gap_dist = 0;
      endfunction

      function longint arc_step(int i);
         longint tab[11] = '{210828714, 124459457, 65760959, 33381290, 16755422,
                             8385879, 4193963, 2097109, 1048571, 524287, 262144};
         if (i < 11) return tab[i];
         if (i <= 28) return longint'(1) <<< (28 - i);
         return 0;
      endfunction

      function longint bearing(longint y_in, longint x_in);
         longint x, y, z, t, dx, dy;
         x = x_in; y = y_in; z = 0;
         if (x == 0 && y == 0) return 0;
         if (x < 0) begin
            t = x;
            if (y >= 0) begin
               x = y; y = -t; z = HALF_PI_Q28;
            end else begin
               x = -y; y = t; z = -HALF_PI_Q28;
            end
         end
         for (int i = 0; i < STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0) begin
               x += dx; y -= dy; z += arc_step(i);
            end else begin
               x -= dx; y += dy; z -= arc_step(i);
            end
         end
         return (z + (longint'(1) <<< 15)) >>> 16;
      endfunction

      function longint unsigned root(longint unsigned v_in);
         longint unsigned v, r, b;
         v = v_in; r = 0; b = 64'd1 << 62;
         while (b > v) b >>= 2;
         while (b != 0) begin
            if (v >= r + b) begin
               v -= r + b; r = (r >> 1) + b;
            end else begin
               r >>= 1;
            end
            b >>= 2;
         end
         return r;
      endfunction

      function void note_request(opcode_type op, request_type r);
         longint qx, qy, qz, qw, yaw, heading, ex, ey, aim_dir, gap_dir, d;
         longint num, den, end_dir, rate, lim;
         longint unsigned ax, ay, span, speed;
         int s;
         command_type c;
         case (op)
            OP_GAP: begin
               gap_ang = r.gap_angle; gap_dist = r.gap_distance;
            end
            OP_GOAL: begin
               goal_x = r.target_x; goal_y = r.target_y;
            end
            OP_ODOM: begin
               qx = r.quat_x; qy = r.quat_y; qz = r.quat_z; qw = r.quat_w;
               yaw = bearing(2 * (qw * qz + qx * qy),
                             (longint'(1) <<< 28) - 2 * (qy * qy + qz * qz));
               if (!has_origin) begin
                  org_x = r.pos_x; org_y = r.pos_y; org_head = yaw; has_origin = 1;
               end
               heading = yaw - org_head;
               ex = goal_x - (longint'(r.pos_x) - org_x);
               ey = goal_y - (longint'(r.pos_y) - org_y);
               ax = ex < 0 ? -ex : ex;
               ay = ey < 0 ? -ey : ey;
               s = 0;
               while (ax >= 64'd1 << 31 || ay >= 64'd1 << 31) begin
                  ax >>= 1; ay >>= 1; s++;
               end
               span = root(ax * ax + ay * ay) << s;
               aim_dir = bearing(ey, ex);
               gap_dir = gap_ang + heading;
               d = gap_dist;
               if (d <= GAP_MIN_Q16) d = GAP_SUB_Q16;
               num = longint'(regs[REG_GWEIGHT]) * 16 * gap_dir + d * aim_dir;
               den = longint'(regs[REG_ALPHA]) * 16 + d;
               end_dir = num / den;
               speed = (64'(regs[REG_LGAIN]) * span + (64'd1 << 15)) >> 16;
               if (speed > regs[REG_LLIM]) speed = regs[REG_LLIM];
               if (speed < regs[REG_LDB]) speed = 0;
               rate = (longint'(regs[REG_AGAIN]) * (end_dir - heading) + 2048) >>> 12;
               lim = regs[REG_ALIM];
               if (rate > lim) rate = lim;
               if (rate < -lim) rate = -lim;
               if ((rate < 0 ? -rate : rate) < longint'(regs[REG_ADB])) rate = 0;
               c.speed = speed[15:0];
               c.rate = rate[16:0];
               pending.insert(pending.size(), c);
            end
            default: ;
         endcase
      endfunction

      function string check_response(logic [RSP_W-1:0] d);
         command_type c;
         string msg;
         msg = "";
         if (pending.size() == 0) return $sformatf("unexpected response %h", d);
         c = pending.pop_front();
         if (d[15:0] !== c.speed)
            msg = {msg, $sformatf(" speed %0d exp %0d", d[15:0], c.speed)};
         if (d[32:16] !== c.rate)
            msg = {msg, $sformatf(" rate %0d exp %0d", $signed(d[32:16]), c.rate)};
         if (d[RSP_W-1:33] !== '0)
            msg = {msg, $sformatf(" fill %h", d[RSP_W-1:33])};
         return msg;
      endfunction
   endclass

   logic             clock = 0;
   logic             reset = 1;
   logic             req_tvalid = 0;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata = '0;
   logic [1:0]       req_tuser = OP_ODOM;
   logic             rsp_tvalid;
   logic             rsp_tready = 0;
   logic [RSP_W-1:0] rsp_tdata;
   logic             csr_we = 0;
   logic [2:0]       csr_index = REG_LGAIN;
   logic [15:0]      csr_wdata = '0;

   scoreboard_type sb = new();
   int errors = 0;
   int quiet = 0;
   int mode = 0;
   opcode_type cur_op;
   request_type cur_req;

   gap_goal_blend_steering #(.CORDIC_STEPS(STEPS)) i_dut (.*);

   always begin
      #2 clock = 1;
      #2 clock = 0;
   end

   task automatic report(string msg);
      $display("mismatch at %0t:%s", $time, msg);
      errors++;
   endtask

   always @(posedge clock) begin
      string msg;
      if (!reset) begin
         quiet++;
         if (req_tvalid && req_tready) begin
            sb.note_request(cur_op, cur_req);
            quiet = 0;
         end
         if (rsp_tvalid && rsp_tready) begin
            msg = sb.check_response(rsp_tdata);
            if (msg != "") report(msg);
            quiet = 0;
         end
         if (quiet >= WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
         end
      end
   end

   // receiver stall pattern follows the current phase
   always @(negedge clock) begin
      if (mode == 2) rsp_tready = $urandom_range(0, 99) >= 54;
      else if (mode == 3) rsp_tready = $urandom_range(0, 99) >= 8;
      else rsp_tready = 1;
   end

   task automatic send(opcode_type op, request_type r);
      @(negedge clock);
      while ((mode == 1 && $urandom_range(0, 99) < 54) ||
             (mode == 3 && $urandom_range(0, 99) < 8)) begin
         req_tvalid = 0;
         @(negedge clock);
      end
      cur_op = op;
      cur_req = r;
      req_tuser = op;
      req_tdata = {r.target_y, r.target_x, r.gap_distance, r.gap_angle, r.quat_w,
                   r.quat_z, r.quat_y, r.quat_x, r.pos_y, r.pos_x};
      req_tvalid = 1;
      do @(posedge clock); while (!(req_tvalid && req_tready));
   endtask

   task automatic drain();
      @(negedge clock);
      req_tvalid = 0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (150) @(posedge clock);
   endtask

   task automatic write_reg(reg_index_type idx, logic [15:0] value);
      @(negedge clock);
      csr_we = 1;
      csr_index = idx;
      csr_wdata = value;
      sb.regs[idx] = value;
      @(negedge clock);
      csr_we = 0;
   endtask

   function automatic logic [31:0] rand_pos();
      if ($urandom_range(0, 9) < 7) return $urandom_range(0, 1 << 22) - (1 << 21);
      return $urandom;
   endfunction

   function automatic logic [15:0] rand_quat();
      if ($urandom_range(0, 9) < 6) return 16'($urandom_range(0, 32768) - 16384);
      return 16'($urandom);
   endfunction

   function automatic request_type rand_request();
      request_type r;
      r.pos_x = rand_pos(); r.pos_y = rand_pos();
      r.quat_x = rand_quat(); r.quat_y = rand_quat();
      r.quat_z = rand_quat(); r.quat_w = rand_quat();
      r.gap_angle = 16'($urandom);
      case ($urandom_range(0, 3))
         0: r.gap_distance = $urandom_range(0, 8000);
         1: r.gap_distance = $urandom_range(0, 1 << 20) - (1 << 19);
         default: r.gap_distance = $urandom;
      endcase
      r.target_x = rand_pos(); r.target_y = rand_pos();
      return r;
   endfunction

   function automatic opcode_type rand_op();
      int k;
      k = $urandom_range(0, 99);
      if (k < 55) return OP_ODOM;
      if (k < 75) return OP_GAP;
      if (k < 95) return OP_GOAL;
      return OP_NONE;
   endfunction

   initial begin
      request_type r;
      reg_index_type idx;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // directed: zero vector, huge errors, boundary gap distances, extremes
      r = '{default: '0};
      r.quat_w = 16'sd16384;
      send(OP_ODOM, r);
      send(OP_NONE, rand_request());
      r.target_x = 32'h7fffffff; r.target_y = 32'h80000000;
      send(OP_GOAL, r);
      r.pos_x = 32'h80000000; r.pos_y = 32'h7fffffff;
      send(OP_ODOM, r);
      r.gap_distance = 3276; r.gap_angle = 16'h7fff;
      send(OP_GAP, r);
      send(OP_ODOM, r);
      r.gap_distance = 3277; r.gap_angle = 16'h8000;
      send(OP_GAP, r);
      r.quat_w = '0; r.quat_y = 16'sd16384; r.quat_z = 16'sd16384;
      send(OP_ODOM, r);
      r.quat_y = -16'sd16384; r.quat_z = '0; r.quat_x = -16'sd16384;
      send(OP_ODOM, r);
      r.gap_distance = 32'h80000000;
      send(OP_GAP, r);
      r.quat_x = 16'h8000; r.quat_y = 16'h7fff; r.quat_z = 16'h8000; r.quat_w = 16'h7fff;
      send(OP_ODOM, r);
      r.gap_distance = 32'h7fffffff;
      send(OP_GAP, r);
      r.target_x = 32'h80000000; r.target_y = 32'h80000000;
      send(OP_GOAL, r);
      r.pos_x = 32'h7fffffff; r.pos_y = 32'h7fffffff;
      send(OP_ODOM, r);
      r.target_x = '0; r.target_y = 1 << 16;
      send(OP_GOAL, r);
      r = '{default: '0}; r.quat_w = -16'sd16384;
      send(OP_ODOM, r);
      send(OP_NONE, r);
      drain();

      for (int ph = 0; ph < 6; ph++) begin
         mode = ph % 4;
         for (int i = 0; i < 8; i++) begin
            idx = reg_index_type'(i);
            case (ph)
               1: write_reg(idx, 16'h0000);
               2: write_reg(idx, 16'hffff);
               4: write_reg(idx, (i == 6 || i == 7) ? 16'($urandom_range(0, 600))
                                                   : 16'($urandom_range(1000, 9000)));
               5: write_reg(idx, 16'($urandom));
               default: ;
            endcase
         end
         for (int n = 0; n < ITEMS_PER_PHASE; n++) send(rand_op(), rand_request());
         drain();
      end

      if (errors == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end

endmodule
